// ===== rtl/core/assert_macros.svh =====
// Assertion macros of the RTL, included by the arbiter unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/core/frs_pkg.sv =====
// Types, sizes and codes of the fair resource-set arbiter.
package frs_pkg;

  localparam int RESOURCES   = 8;
  localparam int QUEUE_DEPTH = 8;
  localparam int MAX_RESULTS = 8;

  localparam int WHO_W  = 3;
  localparam int NEED_W = 8;
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int IDX_W  = $clog2(QUEUE_DEPTH);
  localparam int N_W    = $clog2(MAX_RESULTS + 1);

  typedef logic [RESOURCES-1:0] res_t;

  typedef struct packed {
    logic [WHO_W-1:0] who;
    res_t             need;
  } entry_t;

  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctl_t;

  typedef enum logic [1:0] {
    ST_GRANTED,
    ST_QUEUED,
    ST_NONE,
    ST_REJECTED
  } status_t;

  typedef enum logic {
    CMD_REQUEST,
    CMD_RELEASE
  } cmd_t;

  // Map the 8-bit need field onto the resource vector; extra bits are ignored.
  function automatic res_t to_res(input logic [NEED_W-1:0] m);
    logic [31:0] w;
    res_t        r;
    w = 32'(m);
    for (int i = 0; i < RESOURCES; i++) begin
      r[i] = w[i];
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/frs_if.sv =====
// Valid/ready channel interfaces of the arbiter.
interface frs_req_if;
  logic                      valid;
  logic                      ready;
  logic                      command;
  logic [frs_pkg::WHO_W-1:0]  requester;
  logic [frs_pkg::NEED_W-1:0] need_mask;

  modport source (output valid, command, requester, need_mask, input ready);
  modport sink   (input valid, command, requester, need_mask, output ready);
endinterface

interface frs_res_if;
  logic                     valid;
  logic                     ready;
  logic [frs_pkg::WHO_W-1:0] granted_to;
  frs_pkg::status_t         status;
  logic                     last;

  modport source (output valid, granted_to, status, last, input ready);
  modport sink   (input valid, granted_to, status, last, output ready);
endinterface

// ===== rtl/core/frs_cell.sv =====
// One wait-queue cell: holds an entry, loads it or takes its neighbor's.
module frs_cell (
  input  logic              clk,
  input  frs_pkg::cell_ctl_t ctl,
  input  frs_pkg::entry_t   load_data,
  input  frs_pkg::entry_t   nbr_data,
  output frs_pkg::entry_t   entry
);

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      entry <= load_data;
    end else if (ctl.shift) begin
      entry <= nbr_data;
    end
  end

endmodule

// ===== rtl/core/fair_resource_set_arbiter_unit.sv =====
// Fair resource-set arbiter: FIFO-fair grants of resource bitmasks.
// Request: the outcome is registered from S_REQ once the output slot is free, then back to S_IDLE.
// Release: S_SCAN visits the queue one entry per cycle while the output slot is free, then S_DONE
// registers the final result.
// Output stalls hold the scan; input stays blocked until the last result is registered.
// Reset (rst, synchronous, active high): queue empty, all resources free, output idle.
`include "assert_macros.svh"

module fair_resource_set_arbiter_unit (
  input logic      clk,
  input logic      rst,
  frs_req_if.sink  req,
  frs_res_if.source res
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_REQ,
    S_SCAN,
    S_DONE
  } state_t;

  state_t state;

  // Latched transaction
  logic [frs_pkg::WHO_W-1:0] op_who;
  frs_pkg::res_t            op_need;

  // Arbiter state
  frs_pkg::res_t             busy;
  frs_pkg::res_t             booked;
  logic [frs_pkg::CNT_W-1:0] count;

  // Scan bookkeeping: entries still to visit, entries kept so far, grants made
  logic [frs_pkg::CNT_W-1:0] remain;
  logic [frs_pkg::CNT_W-1:0] kept;
  logic [frs_pkg::N_W-1:0]   grants;
  logic                      first;

  // Latest grant held back until we know whether it is the final one
  logic                     pend_valid;
  logic [frs_pkg::WHO_W-1:0] pend_who;

  // Output register
  logic                     out_valid;
  logic [frs_pkg::WHO_W-1:0] out_who;
  frs_pkg::status_t         out_status;
  logic                     out_last;

  // Cell chain
  frs_pkg::entry_t    cell_q  [frs_pkg::QUEUE_DEPTH];
  frs_pkg::entry_t    chain_in[frs_pkg::QUEUE_DEPTH];
  frs_pkg::cell_ctl_t ctl     [frs_pkg::QUEUE_DEPTH];

  logic                      out_free;
  logic                      out_load;
  frs_pkg::entry_t           head;
  logic                      head_grant;
  logic                      scan_step;
  logic                      req_now;
  logic                      req_fits;
  logic                      req_enqueue;
  logic                      load_en;
  logic [frs_pkg::CNT_W-1:0] load_pos;
  frs_pkg::entry_t           load_data;
  logic [frs_pkg::CNT_W:0]   scan_total;
  logic                      none_due;
  logic                      none_out;

  assign req.ready      = (state == S_IDLE);
  assign res.valid      = out_valid;
  assign res.granted_to = out_who;
  assign res.status     = out_status;
  assign res.last       = out_last;

  // A new result may be written when the output slot is empty or draining.
  assign out_free = !out_valid || res.ready;

  // The head cell is the entry under inspection during a scan.
  assign head       = cell_q[0];
  assign head_grant = (grants < frs_pkg::N_W'(frs_pkg::MAX_RESULTS)) &&
                      ((head.need & busy) == '0) &&
                      ((head.need & booked) == '0);
  assign scan_step  = (state == S_SCAN) && (remain != '0) && out_free;

  // Output slot gets a new result: request outcome, a grant known not to be
  // the final one, or the closing result of a release.
  assign out_load = ((state == S_REQ) && out_free) ||
                    (scan_step && head_grant && pend_valid) ||
                    ((state == S_DONE) && out_free);

  assign req_now     = (count == '0) && ((op_need & busy) == '0);
  assign req_fits    = (count < frs_pkg::CNT_W'(frs_pkg::QUEUE_DEPTH));
  assign req_enqueue = (state == S_REQ) && out_free && !req_now && req_fits;

  // Kept entries are re-appended behind the unvisited ones while the chain
  // shifts toward the head, so order survives and the queue ends up packed.
  assign load_en   = req_enqueue || (scan_step && !head_grant);
  assign load_pos  = req_enqueue ? count : (remain + kept - frs_pkg::CNT_W'(1));
  assign load_data = req_enqueue ? frs_pkg::entry_t'{who: op_who, need: op_need} : head;

  assign scan_total = {1'b0, remain} + {1'b0, kept};

  assign none_due = (state == S_DONE) && out_free && !pend_valid;
  assign none_out = out_valid && out_last && (out_status == frs_pkg::ST_NONE);

  always_comb begin
    for (int i = 0; i < frs_pkg::QUEUE_DEPTH; i++) begin
      ctl[i].shift = scan_step;
      ctl[i].load  = load_en && (load_pos[frs_pkg::IDX_W-1:0] == frs_pkg::IDX_W'(i));
    end
  end

  for (genvar g = 0; g < frs_pkg::QUEUE_DEPTH; g++) begin : g_cell
    if (g == frs_pkg::QUEUE_DEPTH - 1) begin : g_tail
      assign chain_in[g] = '0;
    end else begin : g_mid
      assign chain_in[g] = cell_q[g+1];
    end

    frs_cell u_cell (
      .clk       (clk),
      .ctl       (ctl[g]),
      .load_data (load_data),
      .nbr_data  (chain_in[g]),
      .entry     (cell_q[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      count      <= '0;
      busy       <= '0;
      pend_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (req.valid) begin
            op_who  <= req.requester;
            op_need <= frs_pkg::to_res(req.need_mask);
            if (req.command == frs_pkg::CMD_RELEASE) begin
              busy       <= busy & ~frs_pkg::to_res(req.need_mask);
              booked     <= '0;
              grants     <= '0;
              remain     <= count;
              kept       <= '0;
              first      <= 1'b1;
              pend_valid <= 1'b0;
              state      <= S_SCAN;
            end else begin
              state <= S_REQ;
            end
          end
        end

        S_REQ: begin
          if (out_free) begin
            out_who   <= op_who;
            out_last  <= 1'b1;
            if (req_now) begin
              busy       <= busy | op_need;
              out_status <= frs_pkg::ST_GRANTED;
            end else if (req_fits) begin
              count      <= count + frs_pkg::CNT_W'(1);
              out_status <= frs_pkg::ST_QUEUED;
            end else begin
              out_status <= frs_pkg::ST_REJECTED;
            end
            state <= S_IDLE;
          end
        end

        S_SCAN: begin
          if (remain == '0) begin
            count <= kept;
            state <= S_DONE;
          end else if (out_free) begin
            remain <= remain - frs_pkg::CNT_W'(1);
            first  <= 1'b0;
            if (head_grant) begin
              busy       <= busy | head.need;
              grants     <= grants + frs_pkg::N_W'(1);
              pend_who   <= head.who;
              pend_valid <= 1'b1;
              // the previous grant is now known not to be the final one
              if (pend_valid) begin
                out_who    <= pend_who;
                out_status <= frs_pkg::ST_GRANTED;
                out_last   <= 1'b0;
              end
            end else begin
              kept <= kept + frs_pkg::CNT_W'(1);
              if (first) begin
                booked <= head.need;
              end
            end
          end
        end

        S_DONE: begin
          if (out_free) begin
            out_last  <= 1'b1;
            if (pend_valid) begin
              out_who    <= pend_who;
              out_status <= frs_pkg::ST_GRANTED;
            end else begin
              out_who    <= op_who;
              out_status <= frs_pkg::ST_NONE;
            end
            pend_valid <= 1'b0;
            state      <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Queue occupancy never exceeds the number of cells.
  `ASSERT_IMPL(a_count_range, clk, rst, 1'b1, count <= frs_pkg::CNT_W'(frs_pkg::QUEUE_DEPTH))
  // During a scan, visited-and-kept plus unvisited never exceeds the starting count.
  `ASSERT_IMPL(a_scan_bound, clk, rst, state == S_SCAN, scan_total <= {1'b0, count})
  // A release that granted nobody reports exactly one final "nothing granted".
  `ASSERT_NEXT(a_none_result, clk, rst, none_due, none_out)
  // A grant result during the scan is never marked final.
  `ASSERT_NEXT(a_mid_not_last, clk, rst, scan_step && head_grant && pend_valid, out_valid && !out_last)

endmodule

// ===== tb/sv/tb_fair_resource_set_arbiter_unit.sv =====
// Self-checking testbench of the fair resource-set arbiter unit.
`timescale 1ns / 100ps

module tb_fair_resource_set_arbiter_unit;

  // Generous watchdog: ~110 transactions, up to 8 grants each, every grant
  // waiting out a receiver stall, plus the long hold-off of the pressure test.
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 40;  // more than a full queue scan plus output register
  localparam int RANDOM_ITEMS = 64;
  localparam int PRESSURE_ITEMS = 20;
  localparam int HOLD_OFF_CYCLES = 200;

  // One expected result: who it speaks of, the status code and the last mark.
  typedef struct packed {
    logic [frs_pkg::WHO_W-1:0] who;
    frs_pkg::status_t          status;
    logic                      last;
  } outcome_t;

  logic clk;
  logic rst;

  frs_req_if req_ch ();
  frs_res_if res_ch ();

  fair_resource_set_arbiter_unit uut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .res (res_ch)
  );

  // Predictor state: resources in use and the wait line in FIFO order.
  frs_pkg::res_t   held_res;
  frs_pkg::entry_t wait_line[$];
  // Results still owed by the block, oldest first.
  outcome_t        outcomes_due[$];

  int fail_count;
  int cycle_count;
  int src_idle_pct;
  int snk_idle_pct;
  int stall_left;

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Append one result to the list of results still owed.
  task automatic expect_result(input outcome_t o);
    outcomes_due = {outcomes_due, o};
  endtask

  // Work out what one accepted transaction must produce and advance the
  // predictor state.
  task automatic apply_arbitration(input frs_pkg::cmd_t cmd,
                                   input logic [frs_pkg::WHO_W-1:0] who,
                                   input logic [frs_pkg::NEED_W-1:0] raw);
    frs_pkg::res_t   need;
    frs_pkg::res_t   booked;
    frs_pkg::entry_t kept[$];
    frs_pkg::entry_t e;
    outcome_t        o;
    int              grants;
    need = raw[frs_pkg::RESOURCES-1:0];
    if (cmd == frs_pkg::CMD_REQUEST) begin
      o.who = who;
      o.last = 1'b1;
      if (wait_line.size() == 0 && (need & held_res) == '0) begin
        held_res |= need;
        o.status = frs_pkg::ST_GRANTED;
      end else if (wait_line.size() < frs_pkg::QUEUE_DEPTH) begin
        e.who = who;
        e.need = need;
        wait_line = {wait_line, e};
        o.status = frs_pkg::ST_QUEUED;
      end else begin
        // full line: request dropped, nothing changes
        o.status = frs_pkg::ST_REJECTED;
      end
      expect_result(o);
    end else begin
      held_res &= ~need;
      booked = '0;
      grants = 0;
      // one pass head to tail; a blocked head books its mask so that
      // later entries cannot overtake it on those resources
      foreach (wait_line[i]) begin
        if (grants < frs_pkg::MAX_RESULTS && (wait_line[i].need & held_res) == '0 &&
            (wait_line[i].need & booked) == '0) begin
          held_res |= wait_line[i].need;
          o.who = wait_line[i].who;
          o.status = frs_pkg::ST_GRANTED;
          o.last = 1'b0;
          expect_result(o);
          grants++;
        end else begin
          if (i == 0) begin
            booked = wait_line[i].need;
          end
          kept = {kept, wait_line[i]};
        end
      end
      wait_line = kept;
      if (grants == 0) begin
        // nobody granted: the releaser itself gets the report
        o.who = who;
        o.status = frs_pkg::ST_NONE;
        o.last = 1'b1;
        expect_result(o);
      end else begin
        outcomes_due[outcomes_due.size()-1].last = 1'b1;
      end
    end
  endtask

  // Offer one transaction. Entered and left at a falling edge; valid stays
  // high on return so back-to-back transactions need no drop in between.
  task automatic send_command(input frs_pkg::cmd_t cmd,
                              input logic [frs_pkg::WHO_W-1:0] who,
                              input logic [frs_pkg::NEED_W-1:0] need);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid     <= 1'b1;
    req_ch.command   <= cmd;
    req_ch.requester <= who;
    req_ch.need_mask <= need;
    @(posedge clk);
    while (!req_ch.ready) begin
      @(posedge clk);
    end
    apply_arbitration(cmd, who, need);
    @(negedge clk);
  endtask

  // Random request or release. Request masks are mostly sparse so grants
  // happen; releases mostly free held resources so the line keeps moving.
  task automatic send_random_command();
    frs_pkg::cmd_t              cmd;
    logic [frs_pkg::NEED_W-1:0] need;
    cmd = ($urandom_range(0, 99) < 55) ? frs_pkg::CMD_REQUEST : frs_pkg::CMD_RELEASE;
    if (cmd == frs_pkg::CMD_REQUEST) begin
      case ($urandom_range(0, 9))
        0: need = '0;
        1: need = '1;
        2: need = frs_pkg::NEED_W'($urandom);
        default: need = (frs_pkg::NEED_W'(1) << $urandom_range(0, frs_pkg::NEED_W-1)) |
                        (frs_pkg::NEED_W'($urandom_range(0, 1)) <<
                         $urandom_range(0, frs_pkg::NEED_W-1));
      endcase
    end else begin
      case ($urandom_range(0, 9))
        0, 1: need = frs_pkg::NEED_W'($urandom);
        2: need = '0;
        default: need = frs_pkg::NEED_W'(held_res) &
                        (frs_pkg::NEED_W'($urandom) | frs_pkg::NEED_W'($urandom));
      endcase
    end
    send_command(cmd, frs_pkg::WHO_W'($urandom_range(0, 7)), need);
  endtask

  // Immediate grants on an empty line: empty mask, then every resource.
  task automatic test_immediate_grants();
    send_command(frs_pkg::CMD_REQUEST, 3'd0, 8'h00);
    send_command(frs_pkg::CMD_REQUEST, 3'd7, 8'hFF);
  endtask

  // All resources are held, so every request waits; duplicate requesters
  // are queued as separate entries. The ninth one finds the line full.
  task automatic test_queue_full();
    send_command(frs_pkg::CMD_REQUEST, 3'd1, 8'h03);
    send_command(frs_pkg::CMD_REQUEST, 3'd2, 8'h02);
    send_command(frs_pkg::CMD_REQUEST, 3'd3, 8'h0C);
    send_command(frs_pkg::CMD_REQUEST, 3'd4, 8'h00);
    send_command(frs_pkg::CMD_REQUEST, 3'd1, 8'h30);
    send_command(frs_pkg::CMD_REQUEST, 3'd5, 8'h01);
    send_command(frs_pkg::CMD_REQUEST, 3'd6, 8'hC0);
    send_command(frs_pkg::CMD_REQUEST, 3'd2, 8'h00);
    send_command(frs_pkg::CMD_REQUEST, 3'd3, 8'h55);
  endtask

  // Releases against the full line: empty-mask entries pass a blocked head,
  // the head books its mask so overlapping entries stay put while disjoint
  // ones are granted, then the line drains.
  task automatic test_release_booking();
    send_command(frs_pkg::CMD_RELEASE, 3'd0, 8'h00);
    send_command(frs_pkg::CMD_RELEASE, 3'd7, 8'hFC);
    send_command(frs_pkg::CMD_RELEASE, 3'd6, 8'h03);
    send_command(frs_pkg::CMD_RELEASE, 3'd0, 8'hFF);
  endtask

  // A release on an empty line grants nobody; then a
  // full line of eight entries is granted by a single release.
  task automatic test_burst_grants();
    src_idle_pct = 0;
    snk_idle_pct = 0;
    send_command(frs_pkg::CMD_RELEASE, 3'd0, 8'hFF);
    send_command(frs_pkg::CMD_REQUEST, 3'd4, 8'h04);
    send_command(frs_pkg::CMD_REQUEST, 3'd5, 8'h04);
    for (int i = 0; i < frs_pkg::QUEUE_DEPTH - 1; i++) begin
      send_command(frs_pkg::CMD_REQUEST, frs_pkg::WHO_W'(i), 8'h00);
    end
    send_command(frs_pkg::CMD_RELEASE, 3'd4, 8'h04);
    src_idle_pct = 37;
    snk_idle_pct = 37;
  endtask

  // Random traffic; the first stretch runs with no idling on either side.
  task automatic test_random_traffic();
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == 0) begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end else if (i == 30) begin
        src_idle_pct = 37;
        snk_idle_pct = 37;
      end
      send_random_command();
    end
  endtask

  // Receiver holds off while the sender keeps offering, so the output and
  // then the input of the block stall.
  task automatic test_output_pressure();
    src_idle_pct = 0;
    @(posedge clk);
    stall_left = HOLD_OFF_CYCLES;
    @(negedge clk);
    for (int i = 0; i < PRESSURE_ITEMS; i++) begin
      send_random_command();
    end
    src_idle_pct = 37;
  endtask

  // Receiver: ready changes at the falling edge only.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      res_ch.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      res_ch.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
    end
  end

  // Compare every accepted result against the oldest expectation.
  always @(posedge clk) begin : result_check
    outcome_t o;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (outcomes_due.size() == 0) begin
        $error("unexpected result: granted_to %0d status %0d last %0d",
               res_ch.granted_to, res_ch.status, res_ch.last);
        fail_count++;
      end else begin
        o = outcomes_due.pop_front();
        if (res_ch.granted_to !== o.who) begin
          $error("granted_to: expected %0d, actual %0d", o.who, res_ch.granted_to);
          fail_count++;
        end
        if (res_ch.status !== o.status) begin
          $error("status: expected %0d, actual %0d", o.status, res_ch.status);
          fail_count++;
        end
        if (res_ch.last !== o.last) begin
          $error("last: expected %0d, actual %0d", o.last, res_ch.last);
          fail_count++;
        end
      end
    end
  end

  // Watchdog.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    rst              = 1'b1;
    req_ch.valid     = 1'b0;
    req_ch.command   = frs_pkg::CMD_REQUEST;
    req_ch.requester = '0;
    req_ch.need_mask = '0;
    res_ch.ready     = 1'b0;
    held_res         = '0;
    fail_count       = 0;
    stall_left       = 0;
    src_idle_pct     = 37;
    snk_idle_pct     = 37;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_immediate_grants();
    test_queue_full();
    test_release_booking();
    test_burst_grants();
    test_random_traffic();
    test_output_pressure();

    req_ch.valid <= 1'b0;
    while (outcomes_due.size() != 0) begin
      @(posedge clk);
    end
    // stray results after the last expected one are caught here
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
